[design/bist_pkg.sv]
package bist_pkg;

    localparam int REQ_W     = 2;
    localparam int VAL_W     = 32;
    localparam int CAP_W     = 7;
    localparam int CNT_OUT_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch request, restart scan pointer
        logic scan;        // issue next scan read / compare
        logic finish;      // scan over: settle add, latch flags
        logic shift_init;  // point source at the entry after the match
        logic shift;       // move one entry down
        logic shift_done;  // drop the count after the last move
        logic emit;        // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;
        logic hit;
        logic is_remove;
        logic shift_end;
        logic out_free;
    } t_stat;

endpackage

[design/bist_ram.sv]
module bist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/bist_ctrl.sv]
module bist_ctrl import bist_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                w_cmd.scan = 1'b1;
                if (i_stat.scan_end) begin
                    w_cmd.finish = 1'b1;
                    if (i_stat.hit && i_stat.is_remove) begin
                        w_cmd.shift_init = 1'b1;
                        n_state          = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                w_cmd.shift = 1'b1;
                if (i_stat.shift_end) begin
                    w_cmd.shift_done = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    w_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = w_cmd;

endmodule

[design/bist_dp.sv]
module bist_dp import bist_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CAP_W-1:0]        i_cfg_data,
    input  logic [REQ_W-1:0]        i_req_type,
    input  logic signed [VAL_W-1:0] i_element_value,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_was_present,
    output logic                    o_dropped_full,
    output logic [CNT_OUT_W-1:0]    o_element_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]     r_cap;
    logic [CNT_W-1:0]     r_count;
    logic [REQ_W-1:0]     r_op;
    logic [VAL_W-1:0]     r_value;
    logic [CNT_W-1:0]     r_ptr;
    logic                 r_chk;
    logic [CNT_W-1:0]     r_chk_ptr;
    logic                 r_found;
    logic                 r_drop;
    logic                 r_out_valid;
    logic                 r_out_present;
    logic                 r_out_dropped;
    logic [CNT_OUT_W-1:0] r_out_count;

    logic [VAL_W-1:0] w_rd_data;
    logic             w_hit;
    logic             w_ptr_lt;
    logic             w_room;
    logic             w_is_add;
    logic             w_add_ok;
    logic             w_add_refused;
    logic [CNT_W-1:0] w_dst;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [VAL_W-1:0] w_wdata;

    assign w_hit    = r_chk && (w_rd_data == r_value);
    assign w_ptr_lt = (r_ptr < r_count);
    assign w_is_add = (r_op == REQ_ADD);
    // capacity above DEPTH saturates at DEPTH
    assign w_room   = (CMP_W'(r_count) < CMP_W'(r_cap)) && (r_count < CNT_W'(DEPTH));
    assign w_add_ok      = w_is_add && !w_hit && w_room;
    assign w_add_refused = w_is_add && !w_hit && !w_room;
    assign w_dst         = r_chk_ptr - CNT_W'(1);

    // shift moves have the port during SHIFT, the append only at end of scan
    always_comb begin
        if (i_cmd.finish) begin
            w_we    = w_add_ok;
            w_waddr = r_count[IDX_W-1:0];
            w_wdata = r_value;
        end else begin
            w_we    = i_cmd.shift && r_chk;
            w_waddr = w_dst[IDX_W-1:0];
            w_wdata = w_rd_data;
        end
    end

    bist_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_op    <= i_req_type;
                r_value <= i_element_value;
                r_ptr   <= '0;
                r_chk   <= 1'b0;
            end
            // read issued now, compared next cycle
            if (i_cmd.scan) begin
                if (!w_hit && w_ptr_lt) begin
                    r_chk     <= 1'b1;
                    r_chk_ptr <= r_ptr;
                    r_ptr     <= r_ptr + CNT_W'(1);
                end else begin
                    r_chk <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_found <= w_hit;
                r_drop  <= w_add_refused;
                if (w_add_ok) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            // the scan has already cleared the check flag on a hit
            if (i_cmd.shift_init) begin
                r_ptr <= r_chk_ptr + CNT_W'(1);
            end
            if (i_cmd.shift) begin
                if (w_ptr_lt) begin
                    r_chk     <= 1'b1;
                    r_chk_ptr <= r_ptr;
                    r_ptr     <= r_ptr + CNT_W'(1);
                end else begin
                    r_chk <= 1'b0;
                end
            end
            if (i_cmd.shift_done) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_present <= r_found;
            r_out_dropped <= r_drop;
            r_out_count   <= CNT_OUT_W'(r_count);
        end
    end

    always_comb begin
        o_stat.scan_end  = w_hit || !w_ptr_lt;
        o_stat.hit       = w_hit;
        o_stat.is_remove = (r_op == REQ_REMOVE);
        o_stat.shift_end = !w_ptr_lt && !r_chk;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_was_present   = r_out_present;
    assign o_dropped_full  = r_out_dropped;
    assign o_element_count = r_out_count;

endmodule

[design/bounded_integer_set_table_core.sv]
// Set of distinct signed 32-bit values held packed in a single-port-pair RAM of
// DEPTH entries, in insertion order, with a count. Each input beat adds, removes
// or queries one value (req_type 3 acts as a query) and yields one output beat:
// was_present before the request, dropped_full when an add of a new value met a
// full table, and the count afterwards. The capacity register (reset 64, taken
// as at most DEPTH) may only be written while the block is idle; lowering it
// below the count keeps the held values and refuses further adds. One request is
// handled at a time. The scan reads one RAM entry per cycle; a hit at entry pos
// ends the scan early, and a remove that hits then moves the later entries down
// one per cycle. A stalled output side holds the block before the next
// acceptance. No clearing pass is needed after reset: only entries below the
// count are read.
module bounded_integer_set_table_core import bist_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CAP_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [REQ_W-1:0]        i_req_type,
    input  logic signed [VAL_W-1:0] i_element_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_was_present,
    output logic                    o_dropped_full,
    output logic [CNT_OUT_W-1:0]    o_element_count
);

    t_cmd  w_cmd;
    t_stat w_stat;

    bist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bist_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_element_value (i_element_value),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_was_present   (o_was_present),
        .o_dropped_full  (o_dropped_full),
        .o_element_count (o_element_count)
    );

endmodule

[design/bist_chk.sv]
module bist_chk import bist_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic [REQ_W-1:0]        i_req_type,
    input logic signed [VAL_W-1:0] i_element_value,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic                    o_was_present,
    input logic                    o_dropped_full,
    input logic [CNT_OUT_W-1:0]    o_element_count
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_was_present) && $stable(o_dropped_full)
            && $stable(o_element_count))
        else $error("output beat changed while stalled");

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_req_type) && $stable(i_element_value))
        else $error("input beat changed while waiting");

    // refusal only applies to values not already held
    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_dropped_full && o_was_present))
        else $error("dropped_full with was_present");

    // one request in flight: busy right after an accepted beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat taken while busy");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind bounded_integer_set_table_core bist_chk u_bist_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_req_type      (i_req_type),
    .i_element_value (i_element_value),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_was_present   (o_was_present),
    .o_dropped_full  (o_dropped_full),
    .o_element_count (o_element_count)
);

[tb/tb_bounded_integer_set_table_core.sv]
`timescale 1ns / 100ps

module tb_bounded_integer_set_table_core;
    import bist_pkg::*;

    localparam int TB_DEPTH = 64;
    localparam int POOL_N   = 72;
    localparam logic [REQ_W-1:0] REQ_QUERY_ALIAS = 2'd3;

    typedef struct packed {
        logic                 was_present;
        logic                 dropped_full;
        logic [CNT_OUT_W-1:0] count;
    } t_set_reply;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [REQ_W-1:0] op;
        logic [VAL_W-1:0] val;   // capacity on a config row
        logic             typed;
        t_set_reply       reply;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [29] = '{
        '{ROW_REQ, REQ_QUERY,       32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{ROW_REQ, REQ_ADD,         32'h8000_0000, 1'b1, '{1'b0, 1'b0, 7'd1}},
        '{ROW_REQ, REQ_ADD,         32'h7fff_ffff, 1'b1, '{1'b0, 1'b0, 7'd2}},
        '{ROW_REQ, REQ_ADD,         32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd3}},
        '{ROW_REQ, REQ_ADD,         32'hffff_ffff, 1'b1, '{1'b0, 1'b0, 7'd4}},
        '{ROW_REQ, REQ_ADD,         32'h7fff_ffff, 1'b1, '{1'b1, 1'b0, 7'd4}},
        '{ROW_REQ, REQ_QUERY,       32'h8000_0000, 1'b1, '{1'b1, 1'b0, 7'd4}},
        '{ROW_REQ, REQ_QUERY_ALIAS, 32'hffff_ffff, 1'b1, '{1'b1, 1'b0, 7'd4}},
        '{ROW_REQ, REQ_QUERY_ALIAS, 32'h0000_0005, 1'b0, '0},
        '{ROW_REQ, REQ_REMOVE,      32'h7fff_ffff, 1'b1, '{1'b1, 1'b0, 7'd3}},
        '{ROW_REQ, REQ_REMOVE,      32'h1234_5678, 1'b1, '{1'b0, 1'b0, 7'd3}},
        '{ROW_REQ, REQ_QUERY,       32'hffff_ffff, 1'b0, '0},
        '{ROW_REQ, REQ_REMOVE,      32'h8000_0000, 1'b1, '{1'b1, 1'b0, 7'd2}},
        '{ROW_REQ, REQ_REMOVE,      32'hffff_ffff, 1'b1, '{1'b1, 1'b0, 7'd1}},
        '{ROW_REQ, REQ_REMOVE,      32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd0}},
        '{ROW_REQ, REQ_REMOVE,      32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{ROW_CFG, REQ_ADD,         32'd2,         1'b0, '0},
        '{ROW_REQ, REQ_ADD,         32'h5555_5555, 1'b1, '{1'b0, 1'b0, 7'd1}},
        '{ROW_REQ, REQ_ADD,         32'haaaa_aaaa, 1'b1, '{1'b0, 1'b0, 7'd2}},
        '{ROW_REQ, REQ_ADD,         32'h0000_0003, 1'b1, '{1'b0, 1'b1, 7'd2}},
        '{ROW_REQ, REQ_ADD,         32'h5555_5555, 1'b1, '{1'b1, 1'b0, 7'd2}},
        // capacity now below the count
        '{ROW_CFG, REQ_ADD,         32'd1,         1'b0, '0},
        '{ROW_REQ, REQ_ADD,         32'h0000_0007, 1'b1, '{1'b0, 1'b1, 7'd2}},
        '{ROW_REQ, REQ_REMOVE,      32'haaaa_aaaa, 1'b1, '{1'b1, 1'b0, 7'd1}},
        '{ROW_REQ, REQ_ADD,         32'h0000_0007, 1'b1, '{1'b0, 1'b1, 7'd1}},
        '{ROW_REQ, REQ_REMOVE,      32'h5555_5555, 1'b1, '{1'b1, 1'b0, 7'd0}},
        '{ROW_CFG, REQ_ADD,         32'd0,         1'b0, '0},
        '{ROW_REQ, REQ_ADD,         32'h0000_0009, 1'b1, '{1'b0, 1'b1, 7'd0}},
        '{ROW_CFG, REQ_ADD,         32'd127,       1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CAP_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [REQ_W-1:0]     i_req_type;
    logic [VAL_W-1:0]     i_element_value;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_was_present;
    logic                 o_dropped_full;
    logic [CNT_OUT_W-1:0] o_element_count;

    bounded_integer_set_table_core #(.DEPTH(TB_DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_was_present   (o_was_present),
        .o_dropped_full  (o_dropped_full),
        .o_element_count (o_element_count)
    );

    // shadow of the table and the capacity register
    logic [VAL_W-1:0] held_vals [TB_DEPTH];
    int               held_n;
    logic [CAP_W-1:0] cap_reg;

    t_set_reply       reply_q [$];
    logic [VAL_W-1:0] val_pool [POOL_N];
    bit               quiet;
    int               mismatches;
    int               sent_n;
    int               checked_n;
    int               drop_n;
    int               peak_fill;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_set_reply predict_set_request(logic [REQ_W-1:0] op,
                                                       logic [VAL_W-1:0] v);
        int         pos;
        int         k;
        int         lim;
        t_set_reply r;
        pos = held_n;
        for (k = 0; k < held_n; k++) begin
            if (pos == held_n && held_vals[k] == v) pos = k;
        end
        r.was_present  = (pos < held_n);
        r.dropped_full = 1'b0;
        lim = (cap_reg > TB_DEPTH) ? TB_DEPTH : int'(cap_reg);
        case (op)
            REQ_ADD: begin
                if (!r.was_present) begin
                    if (held_n < lim) begin
                        held_vals[held_n] = v;
                        held_n++;
                    end else begin
                        r.dropped_full = 1'b1;
                    end
                end
            end
            REQ_REMOVE: begin
                if (r.was_present) begin
                    for (k = pos; k < held_n - 1; k++) held_vals[k] = held_vals[k + 1];
                    held_n--;
                end
            end
            default: ;
        endcase
        r.count = held_n[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_set_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reply_q.size() == 0) begin
                report_mismatch("unexpected output beat", 1, 0);
            end else begin
                want = reply_q.pop_front();
                checked_n++;
                if (o_was_present !== want.was_present)
                    report_mismatch("was_present", o_was_present, want.was_present);
                if (o_dropped_full !== want.dropped_full)
                    report_mismatch("dropped_full", o_dropped_full, want.dropped_full);
                if (o_element_count !== want.count)
                    report_mismatch("element_count", o_element_count, want.count);
            end
        end
    end

    // output side: random stall before each beat, ready held until it is taken
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_out_valid && i_out_ready)) @(posedge i_clk);
        end
    end

    task automatic send_req(logic [REQ_W-1:0] op, logic [VAL_W-1:0] v,
                            logic typed, t_set_reply typed_reply);
        t_set_reply r;
        int         gap;
        i_in_valid      <= 1'b1;
        i_req_type      <= op;
        i_element_value <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = predict_set_request(op, v);
        reply_q.push_back(typed ? typed_reply : r);
        sent_n++;
        if (r.dropped_full) drop_n++;
        if (held_n > peak_fill) peak_fill = held_n;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_reg = cap;
    endtask

    task automatic run_random_phase(logic [CAP_W-1:0] cap, int n_items,
                                    int add_pct, int rem_pct);
        int               i;
        int               roll;
        logic [REQ_W-1:0] op;
        logic [VAL_W-1:0] v;
        write_capacity(cap);
        for (i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct) op = REQ_ADD;
            else if (roll < add_pct + rem_pct) op = REQ_REMOVE;
            else op = ($urandom_range(0, 3) == 0) ? REQ_QUERY_ALIAS : REQ_QUERY;
            roll = $urandom_range(0, 99);
            if (roll < 10) v = $urandom;
            else if (op != REQ_ADD && held_n > 0 && roll < 60)
                v = held_vals[$urandom_range(0, held_n - 1)];
            else v = val_pool[$urandom_range(0, POOL_N - 1)];
            send_req(op, v, 1'b0, '0);
        end
    endtask

    initial begin
        int i;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_req_type      <= REQ_QUERY;
        i_element_value <= '0;
        held_n     = 0;
        cap_reg    = CAP_RESET;
        quiet      = 1'b0;
        mismatches = 0;
        sent_n     = 0;
        checked_n  = 0;
        drop_n     = 0;
        peak_fill  = 0;
        for (i = 0; i < POOL_N; i++) val_pool[i] = $urandom;
        val_pool[0] = 32'h8000_0000;
        val_pool[1] = 32'h7fff_ffff;
        val_pool[2] = 32'h0000_0000;
        val_pool[3] = 32'hffff_ffff;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                write_capacity(DIR_ROWS[i].val[CAP_W-1:0]);
            else
                send_req(DIR_ROWS[i].op, DIR_ROWS[i].val, DIR_ROWS[i].typed,
                         DIR_ROWS[i].reply);
        end

        // push adds past DEPTH under a saturated limit, then drain under a low one
        run_random_phase(7'd127, 180, 80, 10);
        run_random_phase(7'd64, 80, 40, 30);
        quiet = 1'b1;
        run_random_phase(7'd20, 120, 25, 60);
        quiet = 1'b0;
        run_random_phase(7'd0, 40, 50, 30);
        run_random_phase(7'd1, 40, 50, 30);
        for (i = 0; i < 5; i++) begin
            quiet = (i % 3 == 2);
            if (i == 4) run_random_phase(7'($urandom_range(65, 126)), 40, 50, 30);
            else run_random_phase(7'($urandom_range(2, 63)), 40, 50, 30);
        end
        quiet = 1'b0;

        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (2 * TB_DEPTH + 10) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d output beats, %0d refused as full.",
                 sent_n, checked_n, drop_n);
        $display("Peak fill %0d of %0d entries; %0d mismatches.",
                 peak_fill, TB_DEPTH, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timed out with %0d beats outstanding.", reply_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
design/bist_pkg.sv
design/bist_ram.sv
design/bist_ctrl.sv
design/bist_dp.sv
design/bounded_integer_set_table_core.sv
design/bist_chk.sv
tb/tb_bounded_integer_set_table_core.sv
